// File: src/dpm_pkg.sv
`timescale 1ns / 1ps
package dpm_pkg;

  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int RAW_W    = 16;
  localparam int SLOPE_W  = 24;
  localparam int OFFSET_W = 28;
  localparam int DIST_W   = 28;
  localparam int DEN_W    = 42;
  localparam int QUO_W    = 42;
  localparam logic [RAW_W-1:0] RAW_LIMIT = 16'd2047;
  localparam logic [SLOPE_W-1:0]  SLOPE_RST  = 24'd51525;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 28'd55884060;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [0:0] OP_WRITE   = 1'b0;
  localparam logic [0:0] OP_PROJECT = 1'b1;

  localparam logic [0:0] REG_SLOPE  = 1'b0;
  localparam logic [0:0] REG_OFFSET = 1'b1;

  // one project beat as it leaves the front part
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             in_frame;
    logic             last;
  } front_beat_t;

endpackage

// File: src/depth_point_to_meters.sv
`timescale 1ns / 1ps
// Depth point to meters: holds one frame of raw depth samples and turns a
// point into its distance 2^40/(offset - slope*raw) in signed Q16. A beat is
// taken every cycle (busy stays low); a write beat gives no result, a project
// beat gives one out_valid strobe, after the memory read, queue, multiply,
// 11-stage divider at 4 quotient bits per stage, and clip.
// The receiver cannot stall, so results leave in order with no backpressure.
module depth_point_to_meters #(
  parameter int FRAME_WIDTH  = dpm_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dpm_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [9:0]  in_column,
  input  logic [8:0]  in_row,
  input  logic [15:0] in_raw_depth,
  input  logic        in_last_point,
  output logic        out_valid,
  output logic [9:0]  out_column,
  output logic [8:0]  out_row,
  output logic signed [27:0] out_distance_q16,
  output logic        out_invalid_depth,
  output logic        out_saturated,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [dpm_pkg::SLOPE_W-1:0]  slope_r;
  logic [dpm_pkg::OFFSET_W-1:0] offset_r;
  logic                         acc;
  logic                         fr_vld, q_ne;
  dpm_pkg::front_beat_t         fr_beat, q_beat;
  logic [dpm_pkg::RAW_W-1:0]    fr_raw, q_raw;

  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign pready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r  <= dpm_pkg::SLOPE_RST;
      offset_r <= dpm_pkg::OFFSET_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        dpm_pkg::REG_SLOPE:  slope_r  <= pwdata[dpm_pkg::SLOPE_W-1:0];
        dpm_pkg::REG_OFFSET: offset_r <= pwdata[dpm_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dpm_pkg::REG_SLOPE:  prdata = {8'd0, slope_r};
      dpm_pkg::REG_OFFSET: prdata = {4'd0, offset_r};
      default:             prdata = '0;
    endcase
  end

  dpm_front #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .op(in_op), .column(in_column),
    .row(in_row), .raw_depth(in_raw_depth), .last_point(in_last_point),
    .beat_vld(fr_vld), .beat(fr_beat), .beat_raw(fr_raw)
  );

  // back never stalls: pop whenever something is queued
  dpm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(fr_vld), .push_beat(fr_beat),
    .push_raw(fr_raw), .pop(q_ne), .not_empty(q_ne), .pop_beat(q_beat),
    .pop_raw(q_raw)
  );

  dpm_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(q_ne), .in_beat(q_beat), .in_raw(q_raw),
    .slope(slope_r), .offset(offset_r), .res_vld(out_valid),
    .res_column(out_column), .res_row(out_row), .res_dist(out_distance_q16),
    .res_invalid(out_invalid_depth), .res_sat(out_saturated),
    .res_last(out_last)
  );
endmodule

// File: src/dpm_front.sv
`timescale 1ns / 1ps
// accepts beats, writes the frame memory, reads it for project beats
module dpm_front #(
  parameter int FRAME_WIDTH  = dpm_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dpm_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic                        op,
  input  logic [dpm_pkg::COL_W-1:0]   column,
  input  logic [dpm_pkg::ROW_W-1:0]   row,
  input  logic [dpm_pkg::RAW_W-1:0]   raw_depth,
  input  logic                        last_point,
  output logic                        beat_vld,
  output dpm_pkg::front_beat_t        beat,
  output logic [dpm_pkg::RAW_W-1:0]   beat_raw
);
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [dpm_pkg::RAW_W-1:0] frame_mem [DEPTH];
  logic                      in_frame;
  logic [AW-1:0]             addr;
  logic [AW+12:0]            addr_full;
  logic                      beat_vld_r;
  dpm_pkg::front_beat_t      beat_r;
  logic [dpm_pkg::RAW_W-1:0] raw_r;

  // address decode
  assign in_frame = ({22'd0, column} < FRAME_WIDTH) && ({23'd0, row} < FRAME_HEIGHT);
  assign addr_full = (AW+13)'(row) * (AW+13)'(FRAME_WIDTH) + (AW+13)'(column);
  assign addr = addr_full[AW-1:0];

  // frame memory, registered read
  always_ff @(posedge clk) begin
    if (acc && op == dpm_pkg::OP_WRITE && in_frame) begin
      frame_mem[addr] <= raw_depth;
    end
    raw_r <= frame_mem[addr];
    beat_r <= '{column: column, row: row, in_frame: in_frame, last: last_point};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_vld_r <= 1'b0;
    end else begin
      beat_vld_r <= acc && op == dpm_pkg::OP_PROJECT;
    end
  end

  assign beat_vld = beat_vld_r;
  assign beat     = beat_r;
  assign beat_raw = raw_r;
endmodule

// File: src/dpm_queue.sv
`timescale 1ns / 1ps
// short fifo between front and back
module dpm_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  dpm_pkg::front_beat_t      push_beat,
  input  logic [dpm_pkg::RAW_W-1:0] push_raw,
  input  logic                      pop,
  output logic                      not_empty,
  output dpm_pkg::front_beat_t      pop_beat,
  output logic [dpm_pkg::RAW_W-1:0] pop_raw
);
  localparam int AW = dpm_pkg::QUEUE_AW;

  dpm_pkg::front_beat_t      beat_q [dpm_pkg::QUEUE_DEPTH];
  logic [dpm_pkg::RAW_W-1:0] raw_q  [dpm_pkg::QUEUE_DEPTH];
  logic [AW-1:0]             wr_r, rd_r;
  logic [AW:0]               cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      beat_q[wr_r] <= push_beat;
      raw_q[wr_r]  <= push_raw;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assign not_empty = cnt_r != '0;
  assign pop_beat  = beat_q[rd_r];
  assign pop_raw   = raw_q[rd_r];
endmodule

// File: src/dpm_back.sv
`timescale 1ns / 1ps
// denominator, pipelined restoring divider of 2^40 by |d|, saturation
module dpm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  dpm_pkg::front_beat_t         in_beat,
  input  logic [dpm_pkg::RAW_W-1:0]    in_raw,
  input  logic [dpm_pkg::SLOPE_W-1:0]  slope,
  input  logic [dpm_pkg::OFFSET_W-1:0] offset,
  output logic                         res_vld,
  output logic [dpm_pkg::COL_W-1:0]    res_column,
  output logic [dpm_pkg::ROW_W-1:0]    res_row,
  output logic signed [dpm_pkg::DIST_W-1:0] res_dist,
  output logic                         res_invalid,
  output logic                         res_sat,
  output logic                         res_last
);
  localparam int DW = dpm_pkg::DEN_W;
  localparam int NS = 41;  // quotient bits of 2^40
  localparam int BPS = 4;  // quotient bits per stage
  localparam int ST = (NS + BPS - 1) / BPS;
  localparam int QUO_W_L = dpm_pkg::QUO_W;

  // stage 0: product and denominator
  logic                 s0_vld_r;
  dpm_pkg::front_beat_t s0_beat_r;
  logic                 s0_inv_r;
  logic [39:0]          s0_prod_r;
  logic [dpm_pkg::OFFSET_W-1:0] s0_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else        s0_vld_r <= in_vld;
    s0_beat_r <= in_beat;
    s0_inv_r  <= !in_beat.in_frame || in_raw >= dpm_pkg::RAW_LIMIT;
    s0_prod_r <= 40'(slope) * 40'(in_raw);
    s0_off_r  <= offset;
  end

  logic signed [DW-1:0] den;
  assign den = $signed(DW'(s0_off_r)) - $signed(DW'(s0_prod_r));

  // stage 1: sign and magnitude
  logic                 s1_vld_r;
  dpm_pkg::front_beat_t s1_beat_r;
  logic                 s1_inv_r, s1_neg_r, s1_zero_r;
  logic [DW-1:0]        s1_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= s0_vld_r;
    s1_beat_r <= s0_beat_r;
    s1_inv_r  <= s0_inv_r;
    s1_neg_r  <= den[DW-1];
    s1_zero_r <= den == '0;
    s1_mag_r  <= den[DW-1] ? DW'(-den) : DW'(den);
  end

  // divider pipeline: dividend 2^40 shifted in msb first
  logic                 dv_vld_r  [ST+1];
  dpm_pkg::front_beat_t dv_beat_r [ST+1];
  logic                 dv_inv_r  [ST+1];
  logic                 dv_neg_r  [ST+1];
  logic                 dv_zero_r [ST+1];
  logic [DW-1:0]        dv_mag_r  [ST+1];
  logic [DW:0]          dv_rem_r  [ST+1];
  logic [QUO_W_L-1:0]   dv_quo_r  [ST+1];

  always_comb begin
    dv_vld_r[0]  = s1_vld_r;
    dv_beat_r[0] = s1_beat_r;
    dv_inv_r[0]  = s1_inv_r;
    dv_neg_r[0]  = s1_neg_r;
    dv_zero_r[0] = s1_zero_r;
    dv_mag_r[0]  = s1_mag_r;
    dv_rem_r[0]  = '0;
    dv_quo_r[0]  = '0;
  end

  for (genvar g = 0; g < ST; g++) begin : g_div
    logic [DW:0]        rem_c [BPS+1];
    logic [QUO_W_L-1:0] quo_c [BPS+1];
    always_comb begin
      rem_c[0] = dv_rem_r[g];
      quo_c[0] = dv_quo_r[g];
      for (int b = 0; b < BPS; b++) begin
        // bit index of dividend taken in this step, msb (40) first
        logic [DW:0] trial;
        logic        dbit;
        dbit  = ((g * BPS + b) == 0) && (g * BPS + b < NS);
        trial = {rem_c[b][DW-1:0], dbit};
        if ((g * BPS + b) < NS) begin
          if (trial >= {1'b0, dv_mag_r[g]}) begin
            rem_c[b+1] = trial - {1'b0, dv_mag_r[g]};
            quo_c[b+1] = {quo_c[b][QUO_W_L-2:0], 1'b1};
          end else begin
            rem_c[b+1] = trial;
            quo_c[b+1] = {quo_c[b][QUO_W_L-2:0], 1'b0};
          end
        end else begin
          rem_c[b+1] = rem_c[b];
          quo_c[b+1] = quo_c[b];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[g+1] <= 1'b0;
      else        dv_vld_r[g+1] <= dv_vld_r[g];
      dv_beat_r[g+1] <= dv_beat_r[g];
      dv_inv_r[g+1]  <= dv_inv_r[g];
      dv_neg_r[g+1]  <= dv_neg_r[g];
      dv_zero_r[g+1] <= dv_zero_r[g];
      dv_mag_r[g+1]  <= dv_mag_r[g];
      dv_rem_r[g+1]  <= rem_c[BPS];
      dv_quo_r[g+1]  <= quo_c[BPS];
    end
  end

  // sign, clip and output register
  localparam logic [QUO_W_L-1:0] POS_MAX = QUO_W_L'(134217727);
  localparam logic [QUO_W_L-1:0] NEG_MAX = QUO_W_L'(134217728);
  logic [QUO_W_L-1:0] q;
  logic               neg, zero, inv;
  logic signed [dpm_pkg::DIST_W-1:0] dist_c;
  logic               sat_c;

  assign q    = dv_quo_r[ST];
  assign neg  = dv_neg_r[ST];
  assign zero = dv_zero_r[ST];
  assign inv  = dv_inv_r[ST];

  always_comb begin
    dist_c = '0;
    sat_c  = 1'b0;
    if (inv) begin
      dist_c = '0;
    end else if (zero) begin
      dist_c = dpm_pkg::DIST_W'(134217727);
      sat_c  = 1'b1;
    end else if (!neg) begin
      if (q > POS_MAX) begin
        dist_c = dpm_pkg::DIST_W'(134217727);
        sat_c  = 1'b1;
      end else begin
        dist_c = q[dpm_pkg::DIST_W-1:0];
      end
    end else begin
      if (q > NEG_MAX) begin
        dist_c = {1'b1, {(dpm_pkg::DIST_W-1){1'b0}}};
        sat_c  = 1'b1;
      end else begin
        dist_c = dpm_pkg::DIST_W'(-q);
      end
    end
  end

  logic                 out_vld_r;
  dpm_pkg::front_beat_t out_beat_r;
  logic signed [dpm_pkg::DIST_W-1:0] out_dist_r;
  logic                 out_inv_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= dv_vld_r[ST];
    out_beat_r <= dv_beat_r[ST];
    out_dist_r <= dist_c;
    out_inv_r  <= inv;
    out_sat_r  <= sat_c;
  end

  assign res_vld     = out_vld_r;
  assign res_column  = out_beat_r.column;
  assign res_row     = out_beat_r.row;
  assign res_dist    = out_dist_r;
  assign res_invalid = out_inv_r;
  assign res_sat     = out_sat_r;
  assign res_last    = out_beat_r.last;
endmodule
